// ===== rtl/pie_pkg.sv =====
// Shared types and defaults for the positional insert/erase table.
`timescale 1ns / 1ps

package pie_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Command codes carried on the request channel
    typedef enum logic [2:0] {
        CMD_READ       = 3'd0,
        CMD_INS_SHIFT  = 3'd1,
        CMD_INS_FAST   = 3'd2,
        CMD_PUSH       = 3'd3,
        CMD_ERS_SHIFT  = 3'd4,
        CMD_ERS_FAST   = 3'd5,
        CMD_POP        = 3'd6,
        CMD_CLEAR      = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    // Per-cycle operation broadcast along the cell row
    typedef enum logic [2:0] {
        OP_HOLD      = 3'd0,
        OP_INS_SHIFT = 3'd1,
        OP_INS_FAST  = 3'd2,
        OP_PUSH      = 3'd3,
        OP_ERS_SHIFT = 3'd4,
        OP_ERS_FAST  = 3'd5
    } op_t;

endpackage

// ===== rtl/pie_cell.sv =====
// One storage cell of the table row: holds one entry and trades it with its neighbors.
`timescale 1ns / 1ps

module pie_cell #(
    parameter int INDEX      = 0,
    parameter int CNT_W      = 5,
    parameter int DATA_WIDTH = pie_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  pie_pkg::op_t          op,
    input  logic [CNT_W-1:0]      position,
    input  logic [CNT_W-1:0]      count,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [DATA_WIDTH-1:0] bcast,
    input  logic [DATA_WIDTH-1:0] left,
    input  logic [DATA_WIDTH-1:0] right,
    output logic [DATA_WIDTH-1:0] data
);

    localparam logic [CNT_W-1:0] IDX  = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX1 = CNT_W'(INDEX + 1);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            pie_pkg::OP_INS_SHIFT:
            begin
                if (IDX == position)
                    data_next = value;
                else if (IDX > position && IDX <= count)
                    data_next = left;
            end
            pie_pkg::OP_INS_FAST:
            begin
                // new word wins when the displaced slot is the append slot
                if (IDX == position)
                    data_next = value;
                else if (IDX == count)
                    data_next = bcast;
            end
            pie_pkg::OP_PUSH:
            begin
                if (IDX == count)
                    data_next = value;
            end
            pie_pkg::OP_ERS_SHIFT:
            begin
                if (IDX >= position && IDX1 < count)
                    data_next = right;
            end
            pie_pkg::OP_ERS_FAST:
            begin
                if (IDX == position)
                    data_next = bcast;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/positional_insert_erase_table_unit.sv =====
// Top level of the positional insert/erase table: command decode, count and result register.
`timescale 1ns / 1ps
// A result word is registered and valid in the cycle after its request word is accepted.
// Throughput: one request per cycle; every cell of the row shifts in the same cycle.
// A request waits only while the held result is stalled on the response side.
// Reset clears the entry count and the response valid; entry cells are not reset
// and hold whatever they had until written.

module positional_insert_erase_table_unit #(
    parameter int CAPACITY   = pie_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = pie_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [2:0]            cmd,
    input  logic [CNT_W-1:0]      position,
    input  logic [DATA_WIDTH-1:0] item_value,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic [DATA_WIDTH-1:0] read_value,
    output logic [CNT_W-1:0]      entry_count,
    output logic                  is_full,
    output logic                  is_empty,
    output logic [1:0]            status
);

    localparam int               IDX_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] CAP   = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

    logic                  in_fire;
    pie_pkg::cmd_t         cmd_d;
    pie_pkg::op_t          op_d;
    pie_pkg::op_t          cell_op;
    pie_pkg::status_t      status_d;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      rd_idx;
    logic [DATA_WIDTH-1:0] bcast;
    logic [DATA_WIDTH-1:0] rd_d;
    logic                  full_now;
    logic                  empty_now;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

    logic                  rsp_valid_reg;
    logic [DATA_WIDTH-1:0] read_value_reg;
    logic [CNT_W-1:0]      entry_count_reg;
    logic                  is_full_reg;
    logic                  is_empty_reg;
    pie_pkg::status_t      status_reg;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign in_fire   = req_valid && !req_stall;
    assign cmd_d     = pie_pkg::cmd_t'(cmd);
    assign full_now  = (count_reg == CAP);
    assign empty_now = (count_reg == '0);

    // Single read port: last entry for erase fast, the addressed entry otherwise
    assign rd_addr = (cmd_d == pie_pkg::CMD_ERS_FAST) ? (count_reg - ONE) : position;
    assign rd_idx  = rd_addr[IDX_W-1:0];
    assign bcast   = cell_data[rd_idx];

    always_comb
    begin
        op_d       = pie_pkg::OP_HOLD;
        status_d   = pie_pkg::ST_DONE;
        count_next = count_reg;
        rd_d       = '0;
        case (cmd_d)
            pie_pkg::CMD_READ:
            begin
                if (position < count_reg)
                    rd_d = bcast;
                else
                    status_d = pie_pkg::ST_BADPOS;
            end
            pie_pkg::CMD_INS_SHIFT, pie_pkg::CMD_INS_FAST:
            begin
                if (full_now)
                    status_d = pie_pkg::ST_FULL;
                else if (position > count_reg)
                    status_d = pie_pkg::ST_BADPOS;
                else
                begin
                    op_d       = (cmd_d == pie_pkg::CMD_INS_SHIFT) ? pie_pkg::OP_INS_SHIFT
                                                                   : pie_pkg::OP_INS_FAST;
                    count_next = count_reg + ONE;
                end
            end
            pie_pkg::CMD_PUSH:
            begin
                if (full_now)
                    status_d = pie_pkg::ST_FULL;
                else
                begin
                    op_d       = pie_pkg::OP_PUSH;
                    count_next = count_reg + ONE;
                end
            end
            pie_pkg::CMD_ERS_SHIFT, pie_pkg::CMD_ERS_FAST:
            begin
                if (empty_now)
                    status_d = pie_pkg::ST_EMPTY;
                else if (position >= count_reg)
                    status_d = pie_pkg::ST_BADPOS;
                else
                begin
                    op_d       = (cmd_d == pie_pkg::CMD_ERS_SHIFT) ? pie_pkg::OP_ERS_SHIFT
                                                                   : pie_pkg::OP_ERS_FAST;
                    count_next = count_reg - ONE;
                end
            end
            pie_pkg::CMD_POP:
            begin
                if (empty_now)
                    status_d = pie_pkg::ST_EMPTY;
                else
                    count_next = count_reg - ONE;
            end
            pie_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                op_d = pie_pkg::OP_HOLD;
            end
        endcase
    end

    // Hold every cell unless a word is taken this cycle
    assign cell_op = in_fire ? op_d : pie_pkg::OP_HOLD;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_d;
            logic [DATA_WIDTH-1:0] right_d;

            if (g == 0)
            begin : g_first
                assign left_d = item_value;
            end
            else
            begin : g_left
                assign left_d = cell_data[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign right_d = cell_data[g];
            end
            else
            begin : g_right
                assign right_d = cell_data[g+1];
            end

            pie_cell #(
                .INDEX      (g),
                .CNT_W      (CNT_W),
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk      (clk),
                .op       (cell_op),
                .position (position),
                .count    (count_reg),
                .value    (item_value),
                .bcast    (bcast),
                .left     (left_d),
                .right    (right_d),
                .data     (cell_data[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            read_value_reg  <= rd_d;
            entry_count_reg <= count_next;
            is_full_reg     <= (count_next == CAP);
            is_empty_reg    <= (count_next == '0);
            status_reg      <= status_d;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;
    assign is_full     = is_full_reg;
    assign is_empty    = is_empty_reg;
    assign status      = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("entry count above capacity");

    a_fire_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> rsp_valid_reg && entry_count_reg == count_reg)
        else $error("accepted word produced no matching result");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(count_reg))
        else $error("entry count moved without an accepted word");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_stall |-> !in_fire)
        else $error("request taken while result is held");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(is_full_reg && is_empty_reg))
        else $error("full and empty both set");

endmodule

// ===== dv/positional_insert_erase_table_unit_test.sv =====
// Self-checking testbench for the positional insert/erase table unit.
`timescale 1ns / 1ps

module positional_insert_erase_table_unit_test;

    localparam int CAP         = pie_pkg::CAPACITY_DEF;
    localparam int DW          = pie_pkg::DATA_WIDTH_DEF;
    localparam int CNT_W       = $clog2(CAP + 1);
    localparam int NUM_WORDS   = 1950;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_LEN    = 80;
    // two copies of the table: one steers stimulus, one predicts results
    localparam int SHADOW      = 0;
    localparam int MIRROR      = 1;

    typedef struct {
        pie_pkg::cmd_t     op;
        logic [CNT_W-1:0]  pos;
        logic [DW-1:0]     value;
    } req_word_t;

    typedef struct {
        logic [DW-1:0]     read_value;
        logic [CNT_W-1:0]  entry_count;
        logic              is_full;
        logic              is_empty;
        pie_pkg::status_t  status;
    } rsp_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    logic [2:0]            cmd = 3'd0;
    logic [CNT_W-1:0]      position = '0;
    logic [DW-1:0]         item_value = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    logic [DW-1:0]         read_value;
    logic [CNT_W-1:0]      entry_count;
    logic                  is_full;
    logic                  is_empty;
    logic [1:0]            status;

    bit [DW-1:0]           words [2][CAP];
    int unsigned           fill [2];

    req_word_t             pending_q[$];
    rsp_word_t             owed_q[$];

    int                    burst_left = 0;
    int                    gap_left = 0;
    int                    words_sent = 0;
    int                    results_checked = 0;
    int                    errors = 0;
    int                    status_seen [4];
    int                    full_results = 0;
    int                    input_held = 0;
    int                    rx_cycles = 0;
    int                    rx_seg_left = 0;
    int                    rx_pct = 0;
    int                    cycles = 0;

    positional_insert_erase_table_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .cmd         (cmd),
        .position    (position),
        .item_value  (item_value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .read_value  (read_value),
        .entry_count (entry_count),
        .is_full     (is_full),
        .is_empty    (is_empty),
        .status      (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one command to table copy t and return the result word it yields.
    function automatic rsp_word_t run_command(input int t, input req_word_t w);
        rsp_word_t   r;
        int unsigned n;
        int          i;
        r.read_value = '0;
        r.status     = pie_pkg::ST_DONE;
        n            = fill[t];
        case (w.op)
            pie_pkg::CMD_READ:
            begin
                if (w.pos < n)
                    r.read_value = words[t][w.pos];
                else
                    r.status = pie_pkg::ST_BADPOS;
            end
            pie_pkg::CMD_INS_SHIFT, pie_pkg::CMD_INS_FAST:
            begin
                if (n >= CAP)
                    r.status = pie_pkg::ST_FULL;
                else if (w.pos > n)
                    r.status = pie_pkg::ST_BADPOS;
                else
                begin
                    if (w.op == pie_pkg::CMD_INS_SHIFT)
                    begin
                        for (i = int'(n); i > w.pos; i--)
                            words[t][i] = words[t][i-1];
                    end
                    else
                        words[t][n] = words[t][w.pos];
                    words[t][w.pos] = w.value;
                    n++;
                end
            end
            pie_pkg::CMD_PUSH:
            begin
                if (n >= CAP)
                    r.status = pie_pkg::ST_FULL;
                else
                begin
                    words[t][n] = w.value;
                    n++;
                end
            end
            pie_pkg::CMD_ERS_SHIFT, pie_pkg::CMD_ERS_FAST:
            begin
                if (n == 0)
                    r.status = pie_pkg::ST_EMPTY;
                else if (w.pos >= n)
                    r.status = pie_pkg::ST_BADPOS;
                else
                begin
                    if (w.op == pie_pkg::CMD_ERS_SHIFT)
                    begin
                        for (i = int'(w.pos); i + 1 < int'(n); i++)
                            words[t][i] = words[t][i+1];
                    end
                    else
                        words[t][w.pos] = words[t][n-1];
                    n--;
                end
            end
            pie_pkg::CMD_POP:
            begin
                if (n == 0)
                    r.status = pie_pkg::ST_EMPTY;
                else
                    n--;
            end
            default:
                n = 0;
        endcase
        fill[t]       = n;
        r.entry_count = CNT_W'(n);
        r.is_full     = (n == CAP);
        r.is_empty    = (n == 0);
        return r;
    endfunction

    task automatic queue_command(input pie_pkg::cmd_t op, input int unsigned pos,
                                 input logic [DW-1:0] v);
        req_word_t w;
        w.op    = op;
        w.pos   = CNT_W'(pos);
        w.value = v;
        void'(run_command(SHADOW, w));
        pending_q.push_back(w);
    endtask

    // Driver: bursts of words with random gaps; hold the word while stalled.
    always @(posedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else
        begin
            if (req_valid && !req_stall)
            begin
                owed_q.push_back(run_command(MIRROR, pending_q[0]));
                pending_q.pop_front();
                words_sent++;
            end
            if (req_valid && req_stall)
                input_held++;
            else if (gap_left != 0 || pending_q.size() == 0)
            begin
                if (gap_left != 0)
                    gap_left--;
                req_valid <= 1'b0;
            end
            else
            begin
                req_valid  <= 1'b1;
                cmd        <= pending_q[0].op;
                position   <= pending_q[0].pos;
                item_value <= pending_q[0].value;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
        end
    end

    // Receiver: stall segments of varying density, plus one long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            rx_cycles++;
            if (rx_seg_left == 0)
            begin
                rx_seg_left = $urandom_range(10, 80);
                case ($urandom_range(0, 2))
                    0: rx_pct = 0;
                    1: rx_pct = 30;
                    default: rx_pct = 70;
                endcase
            end
            else
                rx_seg_left--;
            if (rx_cycles >= HOLD_AT && rx_cycles < HOLD_AT + HOLD_LEN)
                rsp_stall <= 1'b1;
            else
                rsp_stall <= ($urandom_range(0, 99) < rx_pct);
        end
    end

    // Monitor: compare each accepted result word with the oldest prediction.
    always @(posedge clk)
    begin
        rsp_word_t got;
        rsp_word_t exp;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            got.read_value  = read_value;
            got.entry_count = entry_count;
            got.is_full     = is_full;
            got.is_empty    = is_empty;
            got.status      = pie_pkg::status_t'(status);
            if (owed_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: value=%h count=%0d status=%0d",
                             got.read_value, got.entry_count, got.status);
            end
            else
            begin
                exp = owed_q.pop_front();
                results_checked++;
                status_seen[exp.status]++;
                if (exp.is_full)
                    full_results++;
                if (got.read_value !== exp.read_value || got.entry_count !== exp.entry_count
                    || got.is_full !== exp.is_full || got.is_empty !== exp.is_empty
                    || got.status !== exp.status)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch on result %0d: expected value=%h count=%0d ",
                                  "full=%b empty=%b status=%0d, got value=%h count=%0d ",
                                  "full=%b empty=%b status=%0d"},
                                 results_checked, exp.read_value, exp.entry_count,
                                 exp.is_full, exp.is_empty, exp.status, got.read_value,
                                 got.entry_count, got.is_full, got.is_empty, got.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycles, owed_q.size() + pending_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned   n;
        int unsigned   roll;
        int unsigned   pos;
        int            mode_left;
        bit            grow;
        pie_pkg::cmd_t op;
        logic [DW-1:0] v;

        fill[SHADOW] = 0;
        fill[MIRROR] = 0;

        // Rejects on an empty table, bad insert positions.
        queue_command(pie_pkg::CMD_READ, 0, $urandom);
        queue_command(pie_pkg::CMD_POP, 0, $urandom);
        queue_command(pie_pkg::CMD_ERS_SHIFT, 0, $urandom);
        queue_command(pie_pkg::CMD_ERS_FAST, 3, $urandom);
        queue_command(pie_pkg::CMD_INS_SHIFT, 1, $urandom);
        queue_command(pie_pkg::CMD_INS_FAST, 17, $urandom);
        // Insert at the front and append at count, then fill to capacity.
        queue_command(pie_pkg::CMD_INS_SHIFT, 0, '0);
        queue_command(pie_pkg::CMD_PUSH, 31, '1);
        queue_command(pie_pkg::CMD_INS_FAST, 0, 32'hA5A5_A5A5);
        queue_command(pie_pkg::CMD_INS_SHIFT, 3, 32'h5A5A_5A5A);
        while (fill[SHADOW] < CAP)
            queue_command(pie_pkg::CMD_PUSH, 0, $urandom);
        queue_command(pie_pkg::CMD_PUSH, 0, $urandom);
        queue_command(pie_pkg::CMD_INS_SHIFT, 0, $urandom);
        queue_command(pie_pkg::CMD_INS_FAST, CAP, $urandom);
        queue_command(pie_pkg::CMD_READ, CAP - 1, $urandom);
        queue_command(pie_pkg::CMD_READ, CAP, $urandom);
        queue_command(pie_pkg::CMD_ERS_SHIFT, 0, $urandom);
        queue_command(pie_pkg::CMD_ERS_FAST, 0, $urandom);
        queue_command(pie_pkg::CMD_ERS_SHIFT, fill[SHADOW] - 1, $urandom);
        queue_command(pie_pkg::CMD_ERS_FAST, fill[SHADOW], $urandom);
        queue_command(pie_pkg::CMD_POP, 0, $urandom);
        queue_command(pie_pkg::CMD_CLEAR, 0, $urandom);
        queue_command(pie_pkg::CMD_READ, 0, $urandom);

        // Random phase: alternate growing and shrinking drifts so the table
        // sweeps between empty and full; mostly legal positions.
        grow      = 1'b1;
        mode_left = 0;
        while (pending_q.size() < NUM_WORDS)
        begin
            if (mode_left == 0)
            begin
                grow      = ~grow;
                mode_left = $urandom_range(20, 60);
            end
            else
                mode_left--;
            n    = fill[SHADOW];
            roll = $urandom_range(0, 99);
            if (roll < 2)
                op = pie_pkg::CMD_CLEAR;
            else if (roll < 22)
                op = pie_pkg::CMD_READ;
            else if (roll < (grow ? 75 : 40))
                op = pie_pkg::cmd_t'($urandom_range(1, 3));
            else
                op = pie_pkg::cmd_t'($urandom_range(4, 6));
            if ($urandom_range(0, 9) == 0 || op == pie_pkg::CMD_PUSH
                || op == pie_pkg::CMD_POP || op == pie_pkg::CMD_CLEAR)
                pos = $urandom_range(0, 31);
            else if (op == pie_pkg::CMD_INS_SHIFT || op == pie_pkg::CMD_INS_FAST)
                pos = $urandom_range(0, n);
            else
                pos = (n == 0) ? 0 : $urandom_range(0, n - 1);
            case ($urandom_range(0, 9))
                0: v = '0;
                1: v = '1;
                default: v = $urandom;
            endcase
            queue_command(op, pos, v);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || owed_q.size() != 0)
            @(posedge clk);
        // drain: allow a stray late word to show up
        repeat (8) @(posedge clk);

        $display({"Checked %0d results from %0d commands: %0d done, %0d full rejects, ",
                  "%0d empty rejects, %0d bad positions."},
                 results_checked, words_sent, status_seen[pie_pkg::ST_DONE],
                 status_seen[pie_pkg::ST_FULL], status_seen[pie_pkg::ST_EMPTY],
                 status_seen[pie_pkg::ST_BADPOS]);
        $display("Table at capacity in %0d results; request side held off %0d cycles.",
                 full_results, input_held);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
